[rtl/boxcar_filtered_resampler_top_defines.svh]
// Assertion macros for the boxcar filtered resampler.
`ifndef BOXCAR_FILTERED_RESAMPLER_TOP_DEFINES_SVH
`define BOXCAR_FILTERED_RESAMPLER_TOP_DEFINES_SVH

// Consequent in the cycle after the antecedent.
`define RBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbf check failed");

// Consequent in the same cycle as the antecedent.
`define RBF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbf check failed");

`endif

[rtl/rbf_pkg.sv]
// Shared types and constants of the boxcar filtered resampler.
package rbf_pkg;

  localparam int MaxFactorDef = 32;
  localparam int SampleBits   = 16;
  localparam int MaxResults   = 48;
  localparam int CntBits      = 7;

  localparam logic [1:0] ModeDecim  = 2'd0;
  localparam logic [1:0] ModeRepeat = 2'd1;
  localparam logic [1:0] ModeFiltD  = 2'd2;
  localparam logic [1:0] ModeFiltI  = 2'd3;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegFactor = 2'd1;
  localparam logic [1:0] RegStart  = 2'd2;
  localparam logic [1:0] RegEnd    = 2'd3;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_in;
    logic                         stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_out;
    logic                         last_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  resample_factor;
    logic [31:0] segment_start;
    logic [31:0] segment_end;
  } cfg_t;

endpackage

[rtl/boxcar_filtered_resampler_top.sv]
// Boxcar filtered resampler top level: register port, engine, window memory, divider.
//
// Samples enter on the in_* valid/ready channel as one transfer each; results
// leave on the out_* valid/ready channel, last_out set on the final result of
// a stream (plain decimate, repeat) or of a segment (filtered modes).
// Registers mode, resample_factor, segment_start, segment_end sit on the APB
// port at byte offsets 0, 4, 8 and 12; write them only while the block is idle.
// One sample is handled at a time; in_ready_o is high only between samples.
// A plain sample waits on the serial divider, DW being the serial divider width
// (32 by default). Repeat emits its copies one after another.
// Filtered modes read the taps of each boxcar centre from the window memory one
// at a time, and the average goes through the shared restoring divider one
// quotient bit per cycle.
// Filtered interpolation gives up to n centres per sample, more when a segment closes.
// When the receiver stalls, the output register holds its result and the
// engine waits before producing the next one; no result is lost.
// Reset clears the stream indices and pointers, the held result and the registers to their
// defaults; the window memory is not cleared.
`include "boxcar_filtered_resampler_top_defines.svh"
module boxcar_filtered_resampler_top #(
  parameter int MAX_FACTOR = rbf_pkg::MaxFactorDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rbf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbf_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rbf_pkg::*;

  localparam int PW    = $clog2(MAX_FACTOR + 1);
  localparam int TB    = SampleBits + $clog2(MAX_FACTOR + 1);
  localparam int CW    = $clog2(MAX_FACTOR + 2);
  localparam int SB2   = TB + CW;
  localparam int DW    = (SB2 > 32) ? SB2 : 32;
  localparam int Depth = MAX_FACTOR + 1;

  cfg_t cfg_q;
  logic cfg_wr;

  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [TB-1:0] ram_wdata, ram_rdata;
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quo;
  logic [CW-1:0] div_divisor, div_rem;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= ModeDecim;
      cfg_q.resample_factor <= 6'd1;
      cfg_q.segment_start   <= '0;
      cfg_q.segment_end     <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegMode:   cfg_q.mode            <= pwdata[1:0];
        RegFactor: cfg_q.resample_factor <= pwdata[5:0];
        RegStart:  cfg_q.segment_start   <= pwdata;
        RegEnd:    cfg_q.segment_end     <= pwdata;
        default:   cfg_q.mode            <= cfg_q.mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMode:   prdata = {30'd0, cfg_q.mode};
      RegFactor: prdata = {26'd0, cfg_q.resample_factor};
      RegStart:  prdata = cfg_q.segment_start;
      RegEnd:    prdata = cfg_q.segment_end;
      default:   prdata = '0;
    endcase
  end

  rbf_engine #(
    .MAX_FACTOR(MAX_FACTOR),
    .PW(PW),
    .TB(TB),
    .CW(CW),
    .DW(DW)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_i          (cfg_q),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quo_i      (div_quo),
    .div_rem_i      (div_rem)
  );

  rbf_window_ram #(
    .Depth(Depth),
    .Width(TB),
    .AW(PW)
  ) u_window (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rbf_divider #(
    .DW(DW),
    .VW(CW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  `RBF_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && in_ready_o, !in_ready_o)
  `RBF_ASSERT_SAME(a_no_take_on_new_result, $rose(out_valid_o), !in_ready_o)
  `RBF_ASSERT_NEXT(a_div_start_busy, div_start, !in_ready_o)

endmodule

[rtl/rbf_window_ram.sv]
// Window ring memory, one write port and one registered read port.
module rbf_window_ram #(
  parameter int Depth = 33,
  parameter int Width = 22,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rbf_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module rbf_divider #(
  parameter int DW = 32,
  parameter int VW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, div_q;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[rtl/rbf_engine.sv]
// Sequencer: mode control, window updates, boxcar sums and result output.
module rbf_engine #(
  parameter int MAX_FACTOR = rbf_pkg::MaxFactorDef,
  parameter int PW = $clog2(MAX_FACTOR + 1),
  parameter int TB = rbf_pkg::SampleBits + $clog2(MAX_FACTOR + 1),
  parameter int CW = $clog2(MAX_FACTOR + 2),
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rbf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rbf_pkg::out_item_t out_data_o,
  input  rbf_pkg::cfg_t      cfg_i,
  output logic               ram_we_o,
  output logic [PW-1:0]      ram_waddr_o,
  output logic [TB-1:0]      ram_wdata_o,
  output logic [PW-1:0]      ram_raddr_o,
  input  logic [TB-1:0]      ram_rdata_i,
  output logic               div_start_o,
  output logic [DW-1:0]      div_dividend_o,
  output logic [CW-1:0]      div_divisor_o,
  input  logic               div_done_i,
  input  logic [DW-1:0]      div_quo_i,
  input  logic [CW-1:0]      div_rem_i
);
  import rbf_pkg::*;

  localparam int NB    = $clog2(MAX_FACTOR + 1);
  localparam int SB2   = TB + CW;
  localparam int Depth = MAX_FACTOR + 1;
  localparam int SW    = SampleBits;

  typedef enum logic [4:0] {
    S_IDLE, S_M0_WAIT, S_M0_REL, S_M1_REP, S_PUSH, S_PROC, S_BOX_RD, S_BOX_ACC,
    S_BOX_DIV, S_BOX_WAIT, S_MOD_WAIT, S_ADV, S_CLOSE, S_PUT, S_DONE
  } state_e;

  state_e state_q, ret_q;
  logic signed [SW-1:0] s_q, held_q, res_q, put_val_q;
  logic ends_q, in_seg_q, closing_q, proc_closed_q, closed_q, held_valid_q, put_last_q;
  logic [1:0] mode_q;
  logic [NB-1:0] n_q;
  logic [NB:0] k_q;
  logic [31:0] input_idx_q, exp_idx_q, emit_idx_q;
  logic [PW-1:0] wr_ptr_q, emit_ptr_q, rd_ptr_q;
  logic [CW-1:0] taps_q, rem_taps_q;
  logic signed [SB2-1:0] acc_q;
  logic [CntBits-1:0] res_cnt_q;
  logic out_valid_q;
  out_item_t out_data_q;
  logic div_start_q;
  logic [DW-1:0] div_dividend_q;
  logic [CW-1:0] div_divisor_q;

  logic [7:0] fac_ext;
  logic [NB-1:0] n_c, h;
  logic [NB:0] pushes;
  logic [32:0] emit_ext, exp_ext, hi_raw, last_pos, hi_pos, lo_pos;
  logic proc_go, lo_zero, in_seg_c, closing_c;
  logic [PW-1:0] lo_ptr;
  logic signed [TB-1:0] tap_val, s_ext, mult_ext;
  logic [SB2-1:0] acc_mag;
  logic signed [SW-1:0] sat_val;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    fac_ext = {2'b00, cfg_i.resample_factor};
    if (fac_ext == 8'd0) begin
      n_c = NB'(1);
    end else if (fac_ext > 8'(MAX_FACTOR)) begin
      n_c = NB'(MAX_FACTOR);
    end else begin
      n_c = NB'(fac_ext);
    end
  end

  assign in_seg_c  = !closed_q && (input_idx_q >= cfg_i.segment_start)
                     && (input_idx_q < cfg_i.segment_end);
  assign closing_c = !closed_q && (in_data_i.stream_end
                     || ({1'b0, input_idx_q} + 33'd1 >= {1'b0, cfg_i.segment_end}));

  assign h        = n_q >> 1;
  assign pushes   = (mode_q == ModeFiltI) ? {1'b0, n_q} : (NB+1)'(1);
  assign emit_ext = {1'b0, emit_idx_q};
  assign exp_ext  = {1'b0, exp_idx_q};
  assign hi_raw   = emit_ext + 33'(h);
  assign last_pos = exp_ext - 33'd1;
  assign hi_pos   = (hi_raw > last_pos) ? last_pos : hi_raw;
  assign lo_zero  = emit_ext < 33'(h);
  assign lo_pos   = lo_zero ? 33'd0 : emit_ext - 33'(h);
  assign proc_go  = (emit_idx_q < exp_idx_q) && (proc_closed_q || hi_raw < exp_ext);
  assign lo_ptr   = lo_zero ? '0 :
                    (emit_ptr_q >= PW'(h)) ? emit_ptr_q - PW'(h)
                                           : PW'(emit_ptr_q + PW'(Depth) - PW'(h));

  assign s_ext    = TB'(s_q);
  assign mult_ext = (mode_q == ModeFiltI) ? $signed(TB'(n_q)) : $signed(TB'(1));
  assign tap_val  = (k_q == '0) ? TB'(s_ext * mult_ext) : '0;

  assign acc_mag = acc_q[SB2-1] ? SB2'(-acc_q) : SB2'(acc_q);

  always_comb begin
    if (!acc_q[SB2-1]) begin
      if (div_quo_i > DW'((1 << (SW - 1)) - 1)) begin
        sat_val = SW'((1 << (SW - 1)) - 1);
      end else begin
        sat_val = div_quo_i[SW-1:0];
      end
    end else begin
      if (div_quo_i > DW'(1 << (SW - 1))) begin
        sat_val = SW'(1 << (SW - 1));
      end else begin
        sat_val = -$signed(div_quo_i[SW-1:0]);
      end
    end
  end

  assign ram_we_o    = (state_q == S_PUSH) && in_seg_q && (k_q < pushes);
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = tap_val;
  assign ram_raddr_o = rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ret_q         <= S_IDLE;
      input_idx_q   <= '0;
      exp_idx_q     <= '0;
      emit_idx_q    <= '0;
      wr_ptr_q      <= '0;
      emit_ptr_q    <= '0;
      closed_q      <= 1'b0;
      held_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      div_start_q   <= 1'b0;
      res_cnt_q     <= '0;
      proc_closed_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            s_q           <= in_data_i.sample_in;
            ends_q        <= in_data_i.stream_end;
            mode_q        <= cfg_i.mode;
            n_q           <= n_c;
            k_q           <= '0;
            res_cnt_q     <= '0;
            in_seg_q      <= in_seg_c;
            closing_q     <= closing_c;
            proc_closed_q <= 1'b0;
            if (cfg_i.mode == ModeDecim) begin
              div_start_q    <= 1'b1;
              div_dividend_q <= DW'(input_idx_q);
              div_divisor_q  <= CW'(n_c);
              state_q        <= S_M0_WAIT;
            end else if (cfg_i.mode == ModeRepeat) begin
              held_valid_q <= 1'b0;
              state_q      <= S_M1_REP;
            end else begin
              if (cfg_i.mode == ModeFiltI) begin
                held_valid_q <= 1'b0;
              end
              state_q <= S_PUSH;
            end
          end
        end
        S_M0_WAIT: begin
          if (div_done_i) begin
            state_q <= S_M0_REL;
            if (div_rem_i == '0) begin
              held_q       <= s_q;
              held_valid_q <= 1'b1;
              if (held_valid_q) begin
                put_val_q  <= held_q;
                put_last_q <= 1'b0;
                ret_q      <= S_M0_REL;
                state_q    <= S_PUT;
              end
            end
          end
        end
        S_M0_REL: begin
          if (ends_q && held_valid_q) begin
            held_valid_q <= 1'b0;
            put_val_q    <= held_q;
            put_last_q   <= 1'b1;
            ret_q        <= S_DONE;
            state_q      <= S_PUT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_M1_REP: begin
          if (k_q == {1'b0, n_q}) begin
            state_q <= S_DONE;
          end else begin
            put_val_q  <= s_q;
            put_last_q <= ends_q && (k_q + 1'b1 == {1'b0, n_q});
            k_q        <= k_q + 1'b1;
            ret_q      <= S_M1_REP;
            state_q    <= S_PUT;
          end
        end
        S_PUSH: begin
          if (in_seg_q && (k_q < pushes)) begin
            exp_idx_q <= exp_idx_q + 32'd1;
            wr_ptr_q  <= ptr_inc(wr_ptr_q);
            k_q       <= k_q + 1'b1;
            state_q   <= S_PROC;
          end else if (closing_q) begin
            proc_closed_q <= 1'b1;
            state_q       <= S_PROC;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PROC: begin
          if (proc_go) begin
            acc_q      <= '0;
            taps_q     <= CW'(hi_pos - lo_pos + 33'd1);
            rem_taps_q <= CW'(hi_pos - lo_pos + 33'd1);
            rd_ptr_q   <= lo_ptr;
            state_q    <= S_BOX_RD;
          end else if (proc_closed_q) begin
            state_q <= S_CLOSE;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_BOX_RD: begin
          rd_ptr_q <= ptr_inc(rd_ptr_q);
          state_q  <= S_BOX_ACC;
        end
        S_BOX_ACC: begin
          acc_q      <= acc_q + SB2'($signed(ram_rdata_i));
          rem_taps_q <= rem_taps_q - 1'b1;
          state_q    <= (rem_taps_q == CW'(1)) ? S_BOX_DIV : S_BOX_RD;
        end
        S_BOX_DIV: begin
          div_start_q    <= 1'b1;
          div_dividend_q <= DW'(acc_mag);
          div_divisor_q  <= taps_q;
          state_q        <= S_BOX_WAIT;
        end
        S_BOX_WAIT: begin
          if (div_done_i) begin
            res_q <= sat_val;
            if (mode_q == ModeFiltI) begin
              put_val_q  <= sat_val;
              put_last_q <= proc_closed_q && (emit_idx_q + 32'd1 == exp_idx_q);
              ret_q      <= S_ADV;
              state_q    <= S_PUT;
            end else begin
              div_start_q    <= 1'b1;
              div_dividend_q <= DW'(emit_idx_q);
              div_divisor_q  <= CW'(n_q);
              state_q        <= S_MOD_WAIT;
            end
          end
        end
        S_MOD_WAIT: begin
          if (div_done_i) begin
            state_q <= S_ADV;
            if (div_rem_i == '0) begin
              held_q       <= res_q;
              held_valid_q <= 1'b1;
              if (held_valid_q) begin
                put_val_q  <= held_q;
                put_last_q <= 1'b0;
                ret_q      <= S_ADV;
                state_q    <= S_PUT;
              end
            end
          end
        end
        S_ADV: begin
          emit_idx_q <= emit_idx_q + 32'd1;
          emit_ptr_q <= ptr_inc(emit_ptr_q);
          state_q    <= S_PROC;
        end
        S_CLOSE: begin
          closed_q <= 1'b1;
          if (mode_q == ModeFiltD && held_valid_q) begin
            held_valid_q <= 1'b0;
            put_val_q    <= held_q;
            put_last_q   <= 1'b1;
            ret_q        <= S_DONE;
            state_q      <= S_PUT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PUT: begin
          if (!out_valid_q || out_ready_i) begin
            if (res_cnt_q < CntBits'(MaxResults)) begin
              out_valid_q           <= 1'b1;
              out_data_q.sample_out <= put_val_q;
              out_data_q.last_out   <= put_last_q;
              res_cnt_q             <= res_cnt_q + 1'b1;
            end
            state_q <= ret_q;
          end
        end
        S_DONE: begin
          input_idx_q <= input_idx_q + 32'd1;
          if (ends_q) begin
            input_idx_q  <= '0;
            exp_idx_q    <= '0;
            emit_idx_q   <= '0;
            wr_ptr_q     <= '0;
            emit_ptr_q   <= '0;
            closed_q     <= 1'b0;
            held_valid_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign div_start_o    = div_start_q;
  assign div_dividend_o = div_dividend_q;
  assign div_divisor_o  = div_divisor_q;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for boxcar_filtered_resampler_top: streams, predictor, scoreboard.
module tb_top;
  import rbf_pkg::*;

  localparam int WinDepth  = MaxFactorDef + 1;
  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  boxcar_filtered_resampler_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [1:0]  m_mode;
  logic [5:0]  m_factor;
  logic [31:0] m_seg_lo, m_seg_hi;
  longint      ring [WinDepth];
  logic [31:0] in_idx, exp_idx, emit_idx;
  bit          seg_closed, held_ok;
  longint      held_val;
  int          step_results;

  in_item_t    pending_samples[$];
  out_item_t   expected_out[$];
  int          mismatches = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          streams_run = 0;
  bit          idling = 1'b1;
  bit          long_hold_req = 1'b0;

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void emit(longint v, bit last);
    out_item_t r;
    if (step_results >= MaxResults) return;
    r.sample_out = v[15:0];
    r.last_out = last;
    expected_out.push_back(r);
    step_results++;
  endfunction

  function automatic void hold_result(longint v);
    if (held_ok) emit(held_val, 1'b0);
    held_val = v;
    held_ok = 1'b1;
  endfunction

  function automatic void flush_held();
    if (held_ok) emit(held_val, 1'b1);
    held_ok = 1'b0;
  endfunction

  function automatic int eff_factor();
    if (m_factor == 0) return 1;
    if (m_factor > MaxFactorDef) return MaxFactorDef;
    return m_factor;
  endfunction

  function automatic longint boxcar_avg(longint unsigned c, longint unsigned h);
    longint unsigned lo, hi, top, p;
    longint acc;
    lo = (c >= h) ? c - h : 0;
    hi = c + h;
    top = longint'(exp_idx) - 1;
    acc = 0;
    if (hi > top) hi = top;
    for (p = lo; p <= hi; p++) acc += ring[p % WinDepth];
    return clamp16(acc / longint'(hi - lo + 1));
  endfunction

  function automatic void run_centres(bit closing, int n);
    longint unsigned h;
    longint v;
    h = n / 2;
    while (emit_idx < exp_idx &&
           (closing || longint'(emit_idx) + h < longint'(exp_idx))) begin
      v = boxcar_avg(emit_idx, h);
      if (m_mode == ModeFiltI) emit(v, closing && (emit_idx + 1 == exp_idx));
      else if (emit_idx % n == 0) hold_result(v);
      emit_idx++;
    end
  endfunction

  function automatic void clear_stream();
    in_idx = 0;
    exp_idx = 0;
    emit_idx = 0;
    seg_closed = 1'b0;
    held_ok = 1'b0;
    held_val = 0;
  endfunction

  function automatic void predict_sample(in_item_t it);
    longint s;
    int n, pushes;
    bit ends, active, in_seg, closing;
    s = longint'(it.sample_in);
    ends = it.stream_end;
    n = eff_factor();
    step_results = 0;
    if (m_mode == ModeDecim) begin
      if (in_idx % n == 0) hold_result(s);
      if (ends) flush_held();
    end else if (m_mode == ModeRepeat) begin
      held_ok = 1'b0;
      for (int k = 0; k < n; k++) emit(s, ends && k + 1 == n);
    end else begin
      active = !seg_closed;
      in_seg = active && in_idx >= m_seg_lo && in_idx < m_seg_hi;
      closing = active && (ends || {1'b0, in_idx} + 33'd1 >= {1'b0, m_seg_hi});
      pushes = (m_mode == ModeFiltI) ? n : 1;
      if (m_mode == ModeFiltI) held_ok = 1'b0;
      if (in_seg) begin
        for (int k = 0; k < pushes; k++) begin
          ring[exp_idx % WinDepth] = (k == 0) ? s * ((m_mode == ModeFiltI) ? n : 1) : 0;
          exp_idx++;
          run_centres(1'b0, n);
        end
      end
      if (closing) begin
        run_centres(1'b1, n);
        if (m_mode == ModeFiltD) flush_held();
        seg_closed = 1'b1;
      end
    end
    in_idx++;
    if (ends) clear_stream();
  endfunction

  // sender
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample(in_data);
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0 && idling && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sample %0d last %0b",
                     out_data.sample_out, out_data.last_out);
        end else begin
          exp_r = expected_out.pop_front();
          if (exp_r !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       exp_r.sample_out, exp_r.last_out,
                       out_data.sample_out, out_data.last_out);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req <= 1'b0;
        out_gap = 3000;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_samples.size() == 0 && !in_valid && expected_out.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegMode:   m_mode = value[1:0];
      RegFactor: m_factor = value[5:0];
      RegStart:  m_seg_lo = value;
      default:   m_seg_hi = value;
    endcase
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_out.size() > 0 || !in_ready)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic run_stream(logic [1:0] md, logic [5:0] fac, logic [31:0] lo,
                            logic [31:0] hi, int len);
    in_item_t it;
    write_reg(RegMode, {30'd0, md});
    write_reg(RegFactor, {26'd0, fac});
    write_reg(RegStart, lo);
    write_reg(RegEnd, hi);
    for (int k = 0; k < len; k++) begin
      it.sample_in = pick_sample();
      it.stream_end = (k == len - 1);
      pending_samples.push_back(it);
    end
    streams_run++;
    drain();
  endtask

  initial begin
    int md, fac, lo, len;
    logic [31:0] hi;
    m_mode = ModeDecim;
    m_factor = 6'd1;
    m_seg_lo = '0;
    m_seg_hi = '1;
    foreach (ring[i]) ring[i] = 0;
    clear_stream();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_stream(ModeDecim, 6'd3, 0, 32'hffffffff, 6);
    run_stream(ModeRepeat, 6'd2, 0, 32'hffffffff, 3);
    run_stream(ModeFiltD, 6'd4, 2, 9, 10);
    run_stream(ModeFiltI, 6'd32, 0, 3, 3);
    run_stream(ModeFiltD, 6'd5, 5, 2, 3);
    run_stream(ModeFiltI, 6'd0, 10, 20, 3);
    run_stream(ModeDecim, 6'd63, 32'hffffffff, 32'hffffffff, 3);
    long_hold_req <= 1'b1;
    run_stream(ModeRepeat, 6'd6, 0, 32'hffffffff, 12);

    while (samples_sent < 300) begin
      if (samples_sent > 250) idling = 1'b0;
      md = $urandom_range(0, 3);
      fac = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
      if (md == ModeFiltI && fac > 8 && $urandom_range(0, 2) != 0) fac = 3;
      len = $urandom_range(3, 16);
      lo = $urandom_range(0, 4);
      case ($urandom_range(0, 5))
        0: hi = 32'hffffffff;
        1: hi = lo;
        default: hi = lo + $urandom_range(1, 14);
      endcase
      run_stream(md[1:0], fac[5:0], lo, hi, len);
    end

    $display("Ran %0d streams, %0d samples, %0d results checked, all four modes.",
             streams_run, samples_sent, results_checked);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
